// File: rtl/core/nfsf_pkg.sv
package nfsf_pkg;

  // Defaults for the core parameters
  localparam int SLOTS_DEF     = 1024;
  localparam int WORD_BITS_DEF = 64;

  // Fixed field widths
  localparam int TIME_W = 10;
  localparam int FREE_W = 11;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_MARK  = 2'd1,
    ACT_QUERY = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_ADDR,
    ST_SCAN,
    ST_MARK
  } state_e;

endpackage

// File: rtl/core/next_free_slot_finder_core.sv
// Next free slot finder. Keeps a busy bitmap of SLOTS time slots in a
// synchronous RAM of ceil(SLOTS/WORD_BITS) words. Pulse start while busy is
// low to hand in one command: clear (wipe the bitmap), mark (book one slot)
// or query (find the earliest unbooked slot at or after slot_time_i). A query
// answers with free_time_o on the single cycle where strobe_o is high; the
// receiver cannot stall, so it must take the answer then. An answer equal to
// SLOTS means no free slot inside the table; a query or mark at a time at or
// beyond SLOTS answers SLOTS or is dropped. A mark keeps busy high through
// the reciprocal divide, the read and the write back; a query holds busy
// through the divide, the address step and a scan of the bitmap words from
// the word of slot_time_i onward (one RAM read per cycle, up to the first
// word with a free slot or the last word), and strobe_o rises as busy falls.
// A mark or query at or beyond SLOTS is settled in the divide step alone. A
// clear, and the state right after reset, runs a wipe pass over the RAM, one
// word per cycle, with busy high. Code 3 on action_i is ignored and does not raise busy.
module next_free_slot_finder_core #(
  parameter int SLOTS     = nfsf_pkg::SLOTS_DEF,
  parameter int WORD_BITS = nfsf_pkg::WORD_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  action_i,
  input  logic [nfsf_pkg::TIME_W-1:0] slot_time_i,
  output logic                        strobe_o,
  output logic [nfsf_pkg::FREE_W-1:0] free_time_o
);

  localparam int TW     = nfsf_pkg::TIME_W;
  localparam int FW     = nfsf_pkg::FREE_W;
  localparam int NWORDS = (SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int WIDX   = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int BW     = $clog2(WORD_BITS);
  // position width: must hold any bit position of the last word
  localparam int PW     = $clog2(NWORDS * WORD_BITS + 1);
  // t / WORD_BITS as (t * RECIP) >> DIV_SH, exact for every 10-bit t
  localparam int DIV_SH = 18;
  localparam int RECIP  = ((1 << DIV_SH) + WORD_BITS - 1) / WORD_BITS;
  localparam int PRODW  = TW + DIV_SH + 1;

  localparam logic [WIDX-1:0] LAST_WORD = WIDX'(NWORDS - 1);

  nfsf_pkg::state_e state_q, state_d;

  logic [1:0]           action_q, action_d;
  logic [TW-1:0]        time_q, time_d;
  logic [TW-1:0]        quo_q, quo_d;
  logic [BW-1:0]        rem_q, rem_d;
  logic [WIDX-1:0]      word_q, word_d;
  logic [PW-1:0]        base_q, base_d;
  logic                 first_q, first_d;
  logic                 strobe_q, strobe_d;
  logic [FW-1:0]        free_q, free_d;

  // bitmap RAM, one read port with registered data, one write port
  logic [WORD_BITS-1:0] mem [NWORDS];
  logic [WORD_BITS-1:0] rd_data_q;
  logic [WIDX-1:0]      rd_addr;
  logic                 mem_we;
  logic [WIDX-1:0]      mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;

  logic [PRODW-1:0]     prod;
  logic [TW-1:0]        qmul;
  logic [WORD_BITS-1:0] avail;
  logic [BW-1:0]        hit_idx;
  logic [PW-1:0]        pos;
  logic                 out_of_table;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem[rd_addr];
  end

  // divide datapath
  assign prod         = PRODW'(time_q) * PRODW'(RECIP);
  assign qmul         = TW'(quo_q * TW'(WORD_BITS));
  assign out_of_table = 32'(time_q) >= 32'(SLOTS);

  // free bits of the word under scan; first word masks off slots before t
  always_comb begin
    avail = ~rd_data_q;
    if (first_q) begin
      avail = avail & ({WORD_BITS{1'b1}} << rem_q);
    end
  end

  // lowest set bit
  always_comb begin
    hit_idx = '0;
    for (int k = WORD_BITS - 1; k >= 0; k--) begin
      if (avail[k]) begin
        hit_idx = BW'(k);
      end
    end
  end

  assign pos = base_q + PW'(hit_idx);

  always_comb begin
    state_d   = state_q;
    action_d  = action_q;
    time_d    = time_q;
    quo_d     = quo_q;
    rem_d     = rem_q;
    word_d    = word_q;
    base_d    = base_q;
    first_d   = first_q;
    strobe_d  = 1'b0;
    free_d    = free_q;
    rd_addr   = word_q;
    mem_we    = 1'b0;
    mem_waddr = word_q;
    mem_wdata = '0;
    busy      = (state_q != nfsf_pkg::ST_IDLE);

    unique case (state_q)
      nfsf_pkg::ST_CLEAR: begin
        // wipe pass, one word per cycle
        mem_we = 1'b1;
        if (word_q == LAST_WORD) begin
          state_d = nfsf_pkg::ST_IDLE;
        end else begin
          word_d = word_q + WIDX'(1);
        end
      end
      nfsf_pkg::ST_IDLE: begin
        if (start) begin
          action_d = action_i;
          time_d   = slot_time_i;
          case (nfsf_pkg::action_e'(action_i))
            nfsf_pkg::ACT_CLEAR: begin
              word_d  = '0;
              state_d = nfsf_pkg::ST_CLEAR;
            end
            nfsf_pkg::ACT_MARK,
            nfsf_pkg::ACT_QUERY: state_d = nfsf_pkg::ST_DIV;
            default: ;
          endcase
        end
      end
      nfsf_pkg::ST_DIV: begin
        quo_d = TW'(prod >> DIV_SH);
        if (out_of_table) begin
          // query past the table answers SLOTS, a mark there is dropped
          if (action_q == nfsf_pkg::ACT_QUERY) begin
            strobe_d = 1'b1;
            free_d   = FW'(SLOTS);
          end
          state_d = nfsf_pkg::ST_IDLE;
        end else begin
          state_d = nfsf_pkg::ST_ADDR;
        end
      end
      nfsf_pkg::ST_ADDR: begin
        rem_d   = BW'(time_q - qmul);
        word_d  = WIDX'(quo_q);
        base_d  = PW'(qmul);
        first_d = 1'b1;
        rd_addr = WIDX'(quo_q);
        state_d = (action_q == nfsf_pkg::ACT_MARK) ? nfsf_pkg::ST_MARK : nfsf_pkg::ST_SCAN;
      end
      nfsf_pkg::ST_MARK: begin
        // read-modify-write; no other access can overlap
        mem_we    = 1'b1;
        mem_wdata = rd_data_q | (WORD_BITS'(1) << rem_q);
        state_d   = nfsf_pkg::ST_IDLE;
      end
      nfsf_pkg::ST_SCAN: begin
        // next word is fetched while this one is checked
        rd_addr = (word_q == LAST_WORD) ? word_q : word_q + WIDX'(1);
        if (avail != '0) begin
          strobe_d = 1'b1;
          free_d   = (32'(pos) >= 32'(SLOTS)) ? FW'(SLOTS) : FW'(pos);
          state_d  = nfsf_pkg::ST_IDLE;
        end else if (word_q == LAST_WORD) begin
          strobe_d = 1'b1;
          free_d   = FW'(SLOTS);
          state_d  = nfsf_pkg::ST_IDLE;
        end else begin
          word_d  = word_q + WIDX'(1);
          base_d  = base_q + PW'(WORD_BITS);
          first_d = 1'b0;
        end
      end
      default: state_d = nfsf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= nfsf_pkg::ST_CLEAR;
      word_q   <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      word_q   <= word_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    action_q <= action_d;
    time_q   <= time_d;
    quo_q    <= quo_d;
    rem_q    <= rem_d;
    base_q   <= base_d;
    first_q  <= first_d;
    free_q   <= free_d;
  end

  assign strobe_o    = strobe_q;
  assign free_time_o = free_q;

endmodule

// File: rtl/core/nfsf_checker.sv
module nfsf_checker #(
  parameter int SLOTS = nfsf_pkg::SLOTS_DEF
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input logic [1:0]                  action_i,
  input logic                        strobe_o,
  input logic [nfsf_pkg::FREE_W-1:0] free_time_o
);

  // answer never beyond the end-of-table code
  a_answer_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> 32'(free_time_o) <= 32'(SLOTS))
    else $error("answer above SLOTS");

  // a result follows work in progress
  a_strobe_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> $past(busy))
    else $error("strobe without preceding work");

  // results are single-cycle and never back to back
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |=> !strobe_o)
    else $error("strobe held or repeated");

  // mark and clear always occupy the core
  a_mark_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (action_i == nfsf_pkg::ACT_MARK ||
                        action_i == nfsf_pkg::ACT_CLEAR)) |=> busy)
    else $error("mark or clear did not raise busy");

endmodule

bind next_free_slot_finder_core nfsf_checker #(.SLOTS(SLOTS)) u_nfsf_checker (.*);
